@@ src/isct_pkg.sv @@
// ----------------------------------------------------------------------------
// Statistics counter table package
// Shared widths, codes and the entry type of the statistics counter table.
// ----------------------------------------------------------------------------
package isct_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 320;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int INDEX_W    = 5;
  localparam int AMT_W      = 32;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_SUB = 1'b1;

  localparam logic REG_STATS_MASK  = 1'b0;
  localparam logic REG_SQUARE_MASK = 1'b1;

  localparam logic signed [AMT_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;
  localparam logic signed [AMT_W-1:0] MAX_RESET = 32'sh8000_0000;

  // Packed so that the first member lands in the highest bits and the count
  // in the lowest, matching the result tdata layout.
  typedef struct packed {
    logic signed [AMT_W-1:0] max_seen;
    logic signed [AMT_W-1:0] min_seen;
    logic signed [63:0]      square_sum;
    logic signed [63:0]      irq_sum;
    logic signed [63:0]      sum;
    logic        [63:0]      count;
  } entry_t;

endpackage

@@ src/isct_update.sv @@
// ----------------------------------------------------------------------------
// Statistics entry update
// Computes the new value of one table entry from the current entry and
// one add or subtract request.
// ----------------------------------------------------------------------------
module isct_update (
  input  isct_pkg::entry_t                 cur,
  input  logic                             req_type,
  input  logic                             in_interrupt,
  input  logic signed [isct_pkg::AMT_W-1:0] amount,
  input  logic signed [63:0]               square,
  input  logic                             stats_en,
  input  logic                             square_en,
  output isct_pkg::entry_t                 nxt
);
  import isct_pkg::*;

  logic signed [63:0] amount_wide;

  assign amount_wide = 64'(amount);

  always_comb begin
    nxt = cur;
    if (req_type == REQ_ADD) begin
      nxt.count = cur.count + 64'd1;
      if (stats_en) begin
        nxt.sum = cur.sum + amount_wide;
        if (square_en) begin
          nxt.square_sum = cur.square_sum + square;
        end
        if (amount < cur.min_seen) begin
          nxt.min_seen = amount;
        end
        if (amount > cur.max_seen) begin
          nxt.max_seen = amount;
        end
      end
    end else if (stats_en) begin
      if (in_interrupt) begin
        nxt.irq_sum = cur.irq_sum - amount_wide;
      end else begin
        nxt.sum = cur.sum - amount_wide;
      end
    end
  end

endmodule

@@ src/indexed_statistics_counter_table.sv @@
// ----------------------------------------------------------------------------
// Indexed statistics counter table
// Table of count, sum, interrupt sum, square sum, minimum and maximum
// entries, updated by add and subtract requests, one result per request.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the result side is not stalled;
// the entry read-modify-write and the result register sit in a single
// stage after the input register.
// Reset: synchronous; both masks and all sums and counts are cleared, and
// every minimum and maximum is set to its starting extreme at once.
module indexed_statistics_counter_table #(
  parameter int NUM_COUNTERS = 32,
  parameter int AMOUNT_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // counter_index[4:0], amount[36:5], zero padding[39:37]
  input  logic [isct_pkg::IN_DATA_W-1:0]    s_tdata,
  // req_type[0], in_interrupt[1]
  input  logic [isct_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // event_count[63:0], running_sum[127:64], interrupt_sum[191:128],
  // square_sum[255:192], minimum_seen[287:256], maximum_seen[319:288]
  output logic [isct_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [isct_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [isct_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [isct_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import isct_pkg::*;

  localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

  logic [31:0] stats_mask;
  logic [31:0] square_mask;

  logic                     in_valid;
  logic                     in_valid_next;
  logic                     q_req;
  logic                     q_irq;
  logic [INDEX_W-1:0]       q_idx;
  logic signed [AMT_W-1:0]  q_amount;
  logic signed [63:0]       q_square;

  logic                     accept;
  logic                     adv;
  logic signed [AMT_W-1:0]  amount_ext;
  logic signed [63:0]       square_prod;
  logic                     in_range;
  logic [IDX_W-1:0]         sel;
  entry_t                   entries [NUM_COUNTERS];
  entry_t                   cur;
  entry_t                   nxt;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stats_mask  <= '0;
      square_mask <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_STATS_MASK:  stats_mask  <= pwdata;
        REG_SQUARE_MASK: square_mask <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_STATS_MASK:  prdata = stats_mask;
      REG_SQUARE_MASK: prdata = square_mask;
      default:         prdata = '0;
    endcase
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !in_valid || adv;
  assign accept   = s_tvalid && s_tready;

  assign amount_ext  = AMT_W'($signed(s_tdata[INDEX_W +: AMOUNT_BITS]));
  assign square_prod = amount_ext * amount_ext;

  always_comb begin
    if (accept) begin
      in_valid_next = 1'b1;
    end else if (adv) begin
      in_valid_next = 1'b0;
    end else begin
      in_valid_next = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_req    <= s_tuser[0];
      q_irq    <= s_tuser[1];
      q_idx    <= s_tdata[INDEX_W-1:0];
      q_amount <= amount_ext;
      q_square <= square_prod;
    end
  end

  assign in_range = int'(q_idx) < NUM_COUNTERS;
  assign sel      = in_range ? q_idx[IDX_W-1:0] : '0;
  assign cur      = entries[sel];

  isct_update u_update (
    .cur          (cur),
    .req_type     (q_req),
    .in_interrupt (q_irq),
    .amount       (q_amount),
    .square       (q_square),
    .stats_en     (stats_mask[q_idx]),
    .square_en    (square_mask[q_idx]),
    .nxt          (nxt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        entries[i].count      <= '0;
        entries[i].sum        <= '0;
        entries[i].irq_sum    <= '0;
        entries[i].square_sum <= '0;
        entries[i].min_seen   <= MIN_RESET;
        entries[i].max_seen   <= MAX_RESET;
      end
    end else if (in_valid && adv && in_range) begin
      entries[sel] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      m_tdata <= in_range ? OUT_DATA_W'(nxt) : '0;
    end
  end

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && adv) |=> m_tvalid)
    else $error("Result register did not take the pending request.");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (in_valid && adv && !in_range) |=> (m_tdata == '0))
    else $error("Out-of-range request produced a nonzero result.");

  a_add_counts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && adv && in_range && q_req == REQ_ADD)
      |=> (m_tdata[63:0] == $past(cur.count) + 64'd1))
    else $error("Add request did not increment the event count.");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (in_valid && adv && in_range && q_req == REQ_ADD && stats_mask[q_idx])
      |=> ($signed(m_tdata[287:256]) <= $signed(m_tdata[319:288])))
    else $error("Minimum exceeds maximum after a tracked add.");
`endif

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Statistics counter table testbench
// Drives add and subtract requests into the counter table under several
// mask settings, predicts every returned entry and compares it field by
// field. Both stream sides idle at random, and the result side holds off
// once for a long stretch so that the request side backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import isct_pkg::*;

  localparam int NUM_CNT = 32;

  class stats_scoreboard;
    entry_t            entries[NUM_CNT];
    logic [31:0]       stats_mask;
    logic [31:0]       square_mask;
    entry_t            pending_entries[$];
    int                results;
    int                mismatches;
    string             field_name[6] = '{"event_count", "running_sum", "interrupt_sum",
                                         "square_sum", "minimum_seen", "maximum_seen"};

    function new();
      foreach (entries[i]) begin
        entries[i] = '0;
        entries[i].min_seen = MIN_RESET;
        entries[i].max_seen = MAX_RESET;
      end
      stats_mask = '0;
      square_mask = '0;
      results = 0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function void note_request(logic req, logic [INDEX_W-1:0] idx,
                               logic signed [AMT_W-1:0] amt, logic irq);
      entry_t e;
      logic signed [63:0] a64;
      if (idx >= NUM_CNT) begin
        pending_entries.push_back('0);
        return;
      end
      e = entries[idx];
      a64 = amt;
      if (req == REQ_ADD) begin
        e.count = e.count + 64'd1;
        if (stats_mask[idx]) begin
          e.sum = e.sum + a64;
          if (square_mask[idx]) e.square_sum = e.square_sum + a64 * a64;
          if ($signed(amt) < $signed(e.min_seen)) e.min_seen = amt;
          if ($signed(amt) > $signed(e.max_seen)) e.max_seen = amt;
        end
      end else if (stats_mask[idx]) begin
        if (irq) e.irq_sum = e.irq_sum - a64;
        else e.sum = e.sum - a64;
      end
      entries[idx] = e;
      pending_entries.push_back(e);
    endfunction

    function void check_result(entry_t got);
      entry_t want;
      logic [63:0] w[6];
      logic [63:0] g[6];
      results++;
      if (pending_entries.size() == 0) begin
        flag("result transaction with no request outstanding");
        return;
      end
      want = pending_entries.pop_front();
      w = '{want.count, want.sum, want.irq_sum, want.square_sum,
            {32'd0, want.min_seen}, {32'd0, want.max_seen}};
      g = '{got.count, got.sum, got.irq_sum, got.square_sum,
            {32'd0, got.min_seen}, {32'd0, got.max_seen}};
      for (int k = 0; k < 6; k++) begin
        if (w[k] !== g[k])
          flag($sformatf("result %0d %s expected %h got %h",
                         results, field_name[k], w[k], g[k]));
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata = '0;   // counter_index[4:0], amount[36:5], zero[39:37]
  logic [IN_USER_W-1:0]    s_tuser = '0;   // req_type[0], in_interrupt[1]
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]   paddr = '0;
  logic [CFG_DATA_W-1:0]   pwdata = '0;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  stats_scoreboard sb = new();

  int tx_calm = 0;
  int rx_run = 0;
  int rx_stall = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic [INDEX_W-1:0] last_index = '0;

  indexed_statistics_counter_table #(
    .NUM_COUNTERS(NUM_CNT),
    .AMOUNT_BITS (AMT_W)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls with quiet stretches, and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(entry_t'(m_tdata));
      if (!hold_done && sb.results >= 400) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_run > 0) begin
        rx_run--;
        m_tready <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        rx_stall = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(8, 40);
        rx_run = ($urandom_range(0, 99) < 10) ? $urandom_range(50, 150) : $urandom_range(0, 20);
        m_tready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    if (r < 3) tx_calm = $urandom_range(20, 80);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input logic req, input logic [INDEX_W-1:0] idx,
                              input logic signed [AMT_W-1:0] amt, input logic irq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, amt, idx};
    s_tuser <= {irq, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(req, idx, amt, irq);
    last_index = idx;
  endtask

  task automatic send_random();
    logic req;
    logic [INDEX_W-1:0] idx;
    logic signed [AMT_W-1:0] amt;
    req = ($urandom_range(0, 99) < 65) ? REQ_ADD : REQ_SUB;
    idx = $urandom_range(0, 1) ? last_index : INDEX_W'($urandom_range(0, NUM_CNT - 1));
    case ($urandom_range(0, 5))
      0: amt = 32'sh7FFF_FFFF;
      1: amt = 32'sh8000_0000;
      2: amt = $signed(32'($urandom_range(0, 200))) - 32'sd100;
      default: amt = $urandom;
    endcase
    send_request(req, idx, amt, 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_entries.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_masks(input logic [31:0] stats, input logic [31:0] square);
    drain();
    apb_write(REG_STATS_MASK, stats);
    sb.stats_mask = stats;
    apb_write(REG_SQUARE_MASK, square);
    sb.square_mask = square;
  endtask

  initial begin
    logic [31:0] stats_cfg[6];
    logic [31:0] square_cfg[6];
    stats_cfg = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'hFFFF_FFFF, 32'h0, $urandom};
    square_cfg = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'h0, 32'hFFFF_FFFF, $urandom};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With both masks clear, adds only count and subtracts change nothing.
    send_request(REQ_ADD, 5'd3, 32'sd9, 1'b0);
    send_request(REQ_SUB, 5'd3, 32'sd9, 1'b1);

    // Entries 0-7 full statistics, 8-15 no squares, 16-23 square bit only,
    // 24-31 nothing enabled.
    set_masks(32'h0000_FFFF, 32'h00FF_00FF);
    send_request(REQ_ADD, 5'd0, 32'sh7FFF_FFFF, 1'b0);
    send_request(REQ_ADD, 5'd0, 32'sh8000_0000, 1'b1);
    send_request(REQ_ADD, 5'd0, 32'sd0, 1'b0);
    send_request(REQ_ADD, 5'd0, -32'sd1, 1'b0);
    send_request(REQ_SUB, 5'd0, 32'sd5, 1'b0);
    send_request(REQ_SUB, 5'd0, 32'sh8000_0000, 1'b1);
    send_request(REQ_SUB, 5'd0, 32'sh7FFF_FFFF, 1'b1);
    send_request(REQ_ADD, 5'd31, 32'sh7FFF_FFFF, 1'b0);
    send_request(REQ_SUB, 5'd31, 32'sd7, 1'b1);
    send_request(REQ_ADD, 5'd20, -32'sd3, 1'b0);
    send_request(REQ_SUB, 5'd20, 32'sd3, 1'b1);
    send_request(REQ_ADD, 5'd10, 32'sh8000_0000, 1'b0);
    send_request(REQ_SUB, 5'd10, 32'sh7FFF_FFFF, 1'b0);
    for (int k = 0; k < 4; k++) send_request(REQ_ADD, 5'd5, $urandom, 1'b0);

    for (int p = 0; p < 6; p++) begin
      set_masks(stats_cfg[p], square_cfg[p]);
      repeat (222) send_random();
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_entries.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
